>>> design/mtsn_pkg.sv
// Shared types and constants for the min/max timestamp normalizer.
// No dependencies; imported by the front, back and top-level modules.

package mtsn_pkg;

	localparam int TS_W   = 32;	// raw timestamp width
	localparam int NORM_W = 17;	// normalized result field width

	typedef enum logic [2:0] {
		B_IDLE,
		B_SETUP,
		B_READ,
		B_LOAD,
		B_DIV,
		B_OUT
	} back_state_t;

endpackage

>>> design/minmax_timestamp_normalizer_unit.sv
// Top level of the min/max timestamp normalizer.
// Depends on mtsn_pkg, mtsn_ram, mtsn_queue, mtsn_front and mtsn_back.

// Collects a frame of point timestamps (up to MAX_POINTS; extra points are
// dropped and flag overflow on every result) and, once the end-of-frame point
// is in, emits one result per stored point in arrival order:
// (t - min) / (max - min) as an unsigned fraction with FRACTION_BITS fraction
// bits, or the ramp i / N when the frame's first point says it has no
// timestamps. A zero range gives 0. Points are taken at one per clock, but a
// new frame's first point waits for a free bank. The store has two banks, so
// the next frame loads while the previous one drains; a third frame waits
// until the oldest is fully delivered. Each result goes through a store read,
// a divider load, one step per fraction bit in the bit-serial divider of the
// back part, and output, skipping the divider steps when the range is zero;
// the divisor is formed once per frame, and a stalled output waits.

module minmax_timestamp_normalizer_unit import mtsn_pkg::*; #(
	parameter int MAX_POINTS    = 64,
	parameter int FRACTION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [TS_W-1:0]   timestamp,
	input  logic              no_timestamp,
	input  logic              end_of_frame,
	input  logic              in_valid,
	output logic              in_ready,
	output logic [NORM_W-1:0] normalized_time,
	output logic              last_result,
	output logic              overflow,
	output logic              out_valid,
	input  logic              out_ready
);

	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int DESC_W = 1 + CNT_W + 2 * TS_W + 2;

	logic              q_full;
	logic              push;
	logic [DESC_W-1:0] push_data;
	logic              pop;
	logic              head_valid;
	logic [DESC_W-1:0] head_data;
	logic              ram_we;
	logic [IDX_W:0]    ram_waddr;
	logic [TS_W-1:0]   ram_wdata;
	logic              ram_re;
	logic [IDX_W:0]    ram_raddr;
	logic [TS_W-1:0]   ram_rdata;

	mtsn_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.timestamp    (timestamp),
		.no_timestamp (no_timestamp),
		.end_of_frame (end_of_frame),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.q_full       (q_full),
		.push         (push),
		.push_data    (push_data),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata)
	);

	mtsn_ram #(
		.WIDTH(TS_W),
		.DEPTH(2 ** (IDX_W + 1))
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mtsn_queue #(
		.WIDTH(DESC_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	mtsn_back #(
		.MAX_POINTS    (MAX_POINTS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.desc_valid      (head_valid),
		.desc_data       (head_data),
		.pop             (pop),
		.ram_re          (ram_re),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.normalized_time (normalized_time),
		.last_result     (last_result),
		.overflow        (overflow),
		.out_valid       (out_valid),
		.out_ready       (out_ready)
	);

endmodule

>>> design/mtsn_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.

module mtsn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/mtsn_queue.sv
// Two-entry frame descriptor queue between the front and back parts.
// No dependencies; head entry is visible while not empty and leaves on pop.

module mtsn_queue #(
	parameter int WIDTH = 72
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;

	assign full       = fill_q == 2'd2;
	assign head_valid = fill_q != 2'd0;
	assign head_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> design/mtsn_front.sv
// Front part: accepts point requests, stores timestamps, tracks min/max and count,
// and pushes a frame descriptor on end of frame. Depends on mtsn_pkg.

module mtsn_front import mtsn_pkg::*; #(
	parameter int MAX_POINTS = 64,
	localparam int CNT_W     = $clog2(MAX_POINTS + 1),
	localparam int IDX_W     = $clog2(MAX_POINTS),
	localparam int DESC_W    = 1 + CNT_W + 2 * TS_W + 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [TS_W-1:0]   timestamp,
	input  logic              no_timestamp,
	input  logic              end_of_frame,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              q_full,
	output logic              push,
	output logic [DESC_W-1:0] push_data,
	output logic              ram_we,
	output logic [IDX_W:0]    ram_waddr,
	output logic [TS_W-1:0]   ram_wdata
);

	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
		logic [TS_W-1:0]  lo;
		logic [TS_W-1:0]  hi;
		logic             ramp;
		logic             ovf;
	} desc_t;

	logic [CNT_W-1:0] count_q;
	logic [TS_W-1:0]  lo_q;
	logic [TS_W-1:0]  hi_q;
	logic             ramp_q;
	logic             ovf_q;
	logic             bank_q;

	logic             accept;
	logic             first;
	logic             ramp_eff;
	logic             room;
	logic             store;
	logic [TS_W-1:0]  lo_base;
	logic [TS_W-1:0]  hi_base;
	logic [TS_W-1:0]  lo_new;
	logic [TS_W-1:0]  hi_new;
	logic [CNT_W-1:0] count_new;
	logic             ovf_new;
	desc_t            desc;

	// A new frame needs a free bank; a frame in progress already owns one.
	assign first    = count_q == '0;
	assign in_ready = !first || !q_full;
	assign accept   = in_valid && in_ready;

	assign ramp_eff = first ? no_timestamp : ramp_q;
	assign lo_base  = first ? timestamp : lo_q;
	assign hi_base  = first ? timestamp : hi_q;
	assign room     = count_q < CNT_W'(MAX_POINTS);
	assign store    = room && !ramp_eff;

	assign lo_new    = (store && timestamp < lo_base) ? timestamp : lo_base;
	assign hi_new    = (store && timestamp > hi_base) ? timestamp : hi_base;
	assign count_new = room ? count_q + CNT_W'(1) : count_q;
	assign ovf_new   = ovf_q || !room;

	assign ram_we    = accept && store;
	assign ram_waddr = {bank_q, count_q[IDX_W-1:0]};
	assign ram_wdata = timestamp;

	always_comb begin
		desc.bank  = bank_q;
		desc.count = count_new;
		desc.lo    = lo_new;
		desc.hi    = hi_new;
		desc.ramp  = ramp_eff;
		desc.ovf   = ovf_new;
	end

	assign push      = accept && end_of_frame;
	assign push_data = desc;

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q <= lo_new;
			hi_q <= hi_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ramp_q  <= 1'b0;
			ovf_q   <= 1'b0;
			bank_q  <= 1'b0;
		end else if (accept) begin
			if (end_of_frame) begin
				// close the frame and move to the other bank
				count_q <= '0;
				ramp_q  <= 1'b0;
				ovf_q   <= 1'b0;
				bank_q  <= ~bank_q;
			end else begin
				count_q <= count_new;
				ramp_q  <= ramp_eff;
				ovf_q   <= ovf_new;
			end
		end
	end

endmodule

>>> design/mtsn_back.sv
// Back part: walks a stored frame and emits one normalized value per point,
// using a bit-serial restoring divider. Depends on mtsn_pkg.

module mtsn_back import mtsn_pkg::*; #(
	parameter int MAX_POINTS    = 64,
	parameter int FRACTION_BITS = 16,
	localparam int CNT_W        = $clog2(MAX_POINTS + 1),
	localparam int IDX_W        = $clog2(MAX_POINTS),
	localparam int STEP_W       = $clog2(FRACTION_BITS),
	localparam int DESC_W       = 1 + CNT_W + 2 * TS_W + 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              desc_valid,
	input  logic [DESC_W-1:0] desc_data,
	output logic              pop,
	output logic              ram_re,
	output logic [IDX_W:0]    ram_raddr,
	input  logic [TS_W-1:0]   ram_rdata,
	output logic [NORM_W-1:0] normalized_time,
	output logic              last_result,
	output logic              overflow,
	output logic              out_valid,
	input  logic              out_ready
);

	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
		logic [TS_W-1:0]  lo;
		logic [TS_W-1:0]  hi;
		logic             ramp;
		logic             ovf;
	} desc_t;

	back_state_t            state_q;
	back_state_t            state_d;
	logic [IDX_W-1:0]       idx_q;
	logic [TS_W-1:0]        div_q;
	logic [TS_W-1:0]        rem_q;
	logic [FRACTION_BITS:0] quo_q;
	logic [STEP_W-1:0]      step_q;

	desc_t                  d;
	logic                   is_last;
	logic                   div_zero;
	logic                   last_step;
	logic [TS_W-1:0]        num;
	logic [TS_W:0]          rem2;
	logic [TS_W:0]          rem2_sub;
	logic                   ge;

	assign d         = desc_t'(desc_data);
	assign is_last   = (CNT_W'(idx_q) + CNT_W'(1)) == d.count;
	assign div_zero  = div_q == '0;
	assign last_step = step_q == STEP_W'(FRACTION_BITS - 1);

	// numerator: point index in ramp mode, offset from the minimum otherwise
	assign num = d.ramp ? TS_W'(idx_q) :
		(ram_rdata >= d.lo ? ram_rdata - d.lo : '0);

	assign rem2     = {rem_q, 1'b0};
	assign rem2_sub = rem2 - {1'b0, div_q};
	assign ge       = rem2 >= {1'b0, div_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:  if (desc_valid) state_d = B_SETUP;
			B_SETUP: state_d = B_READ;
			B_READ:  state_d = B_LOAD;
			B_LOAD:  state_d = div_zero ? B_OUT : B_DIV;
			B_DIV:   if (last_step) state_d = B_OUT;
			B_OUT: begin
				if (out_ready) begin
					state_d = is_last ? B_IDLE : B_READ;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		out_valid = 1'b0;
		ram_re    = 1'b0;
		pop       = 1'b0;
		unique case (state_q)
			B_READ:  ram_re = 1'b1;
			B_OUT: begin
				out_valid = 1'b1;
				pop       = out_ready && is_last;
			end
			default: begin
				out_valid = 1'b0;
			end
		endcase
	end

	assign ram_raddr       = {d.bank, idx_q};
	assign normalized_time = NORM_W'(quo_q);
	assign last_result     = is_last;
	assign overflow        = d.ovf;

	always_ff @(posedge clk) begin
		case (state_q)
			B_SETUP: begin
				div_q <= d.ramp ? TS_W'(d.count) : d.hi - d.lo;
				idx_q <= '0;
			end
			B_LOAD: begin
				step_q <= '0;
				if (div_zero) begin
					quo_q <= '0;
				end else if (num >= div_q) begin
					// offset at or past the range: integer bit set, fraction zero
					quo_q <= (FRACTION_BITS + 1)'(1);
					rem_q <= '0;
				end else begin
					quo_q <= '0;
					rem_q <= num;
				end
			end
			B_DIV: begin
				rem_q  <= ge ? rem2_sub[TS_W-1:0] : rem2[TS_W-1:0];
				quo_q  <= {quo_q[FRACTION_BITS-1:0], ge};
				step_q <= step_q + STEP_W'(1);
			end
			B_OUT: begin
				if (out_ready && !is_last) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
